FILE: design/open_loop_servo_positioner_top_assert.svh
// Assertion macros for the servo positioner, used by the top-level checks.
`ifndef OPEN_LOOP_SERVO_POSITIONER_TOP_ASSERT_SVH
`define OPEN_LOOP_SERVO_POSITIONER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define OSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define OSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/osp_pkg.sv
`default_nettype none

package osp_pkg;

  // Field and register widths
  localparam int ANGLE_W    = 15;
  localparam int LEVEL_W    = 11;
  localparam int COUNT_W    = 12;
  localparam int PULSE_W    = 11;
  localparam int SWING_W    = 10;
  localparam int SWEEP_W    = 12;
  localparam int STEP_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Angle range in hundredths of a degree
  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 15'd18000;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET = 15'd9000;
  localparam logic [ANGLE_W-1:0] DEADBAND    = 15'd50;

  // Pulse limits in microseconds, and compare level limits
  localparam logic signed [12:0] PULSE_MIN = 13'sd1000;
  localparam logic signed [12:0] PULSE_MAX = 13'sd2000;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 11'd1500;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 11'd2047;

  // level = floor(pulse * period / 20000), done as a fixed-point multiply
  localparam longint unsigned PULSE_REF   = 64'd20000;
  localparam int              LEVEL_SHIFT = 26;

  // ticks = floor((mag * sweep + 9000) / 18000), done as mag * (sweep * K) >> 41
  localparam int              RATE_SHIFT = 41;
  localparam longint unsigned RATE_K     = ((64'd1 << RATE_SHIFT) + 64'd17999) / 64'd18000;
  localparam int              RATE_K_W   = 27;
  localparam int              RATE_W     = SWEEP_W + RATE_K_W;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_ANGLE = 2'd1,
    OP_ROTATE    = 2'd2,
    OP_STOP      = 2'd3
  } osp_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_PULSE  = 2'd0,
    REG_SWING       = 2'd1,
    REG_SWEEP       = 2'd2,
    REG_ROTATE_STEP = 2'd3
  } osp_reg_t;

  typedef struct packed {
    osp_op_t            op;
    logic signed [15:0] goal_cdeg;
    logic               clockwise;
  } osp_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pulse_level;
    logic [ANGLE_W-1:0] angle;
    logic               moving;
    logic [COUNT_W-1:0] remaining_ms;
  } osp_out_t;

  // Settings derived from the registers, handed to the update logic
  typedef struct packed {
    logic [LEVEL_W-1:0] level_stop;
    logic [LEVEL_W-1:0] level_pos;
    logic [LEVEL_W-1:0] level_neg;
    logic [RATE_W-1:0]  tick_rate;
    logic [STEP_W-1:0]  rotate_step;
  } osp_cfg_t;

endpackage

`default_nettype wire

FILE: design/osp_cfg.sv
`default_nettype none

module osp_cfg import osp_pkg::*; #(
  parameter int PERIOD_TICKS = 20000
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output osp_cfg_t                   cfg
);

  // ceil(period * 2^26 / 20000): exact floor for pulses up to 2000 us
  localparam longint unsigned LEVEL_K =
    (64'(PERIOD_TICKS) * (64'd1 << LEVEL_SHIFT) + PULSE_REF - 64'd1) / PULSE_REF;

  logic [PULSE_W-1:0] stop_pulse_r;
  logic [SWING_W-1:0] swing_r;
  logic [SWEEP_W-1:0] sweep_r;
  logic [STEP_W-1:0]  rotate_step_r;

  logic signed [12:0] p_stop;
  logic signed [12:0] p_pos;
  logic signed [12:0] p_neg;
  osp_cfg_t           cfg_nxt;
  osp_cfg_t           cfg_r;

  // clamp to 1000..2000 us, scale to the PWM period, saturate
  function automatic logic [LEVEL_W-1:0] level_of(input logic signed [12:0] p);
    logic [11:0] pc;
    logic [63:0] prod;
    logic [63:0] lvl;
    if (p < PULSE_MIN) begin
      pc = 12'(PULSE_MIN);
    end else if (p > PULSE_MAX) begin
      pc = 12'(PULSE_MAX);
    end else begin
      pc = p[11:0];
    end
    prod = 64'(pc) * LEVEL_K;
    lvl  = prod >> LEVEL_SHIFT;
    return (lvl > 64'(LEVEL_MAX)) ? LEVEL_MAX : lvl[LEVEL_W-1:0];
  endfunction

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_pulse_r  <= 11'd1500;
      swing_r       <= 10'd500;
      sweep_r       <= 12'd1200;
      rotate_step_r <= 15'd15;
    end else if (wr_en) begin
      unique case (osp_reg_t'(wr_index))
        REG_STOP_PULSE:  stop_pulse_r  <= wr_data[PULSE_W-1:0];
        REG_SWING:       swing_r       <= wr_data[SWING_W-1:0];
        REG_SWEEP:       sweep_r       <= wr_data[SWEEP_W-1:0];
        REG_ROTATE_STEP: rotate_step_r <= wr_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // derived levels and tick rate, registered behind the register file
  always_comb begin
    p_stop = $signed({2'b00, stop_pulse_r});
    p_pos  = $signed({2'b00, stop_pulse_r}) + $signed({3'b000, swing_r});
    p_neg  = $signed({2'b00, stop_pulse_r}) - $signed({3'b000, swing_r});
    cfg_nxt.level_stop  = level_of(p_stop);
    cfg_nxt.level_pos   = level_of(p_pos);
    cfg_nxt.level_neg   = level_of(p_neg);
    cfg_nxt.tick_rate   = RATE_W'(sweep_r) * RATE_W'(RATE_K);
    cfg_nxt.rotate_step = rotate_step_r;
  end

  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: design/osp_core.sv
`default_nettype none

module osp_core import osp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     advance,
  input  wire osp_in_t  item,
  input  wire osp_cfg_t cfg,
  output osp_out_t      result
);

  localparam int TPROD_W = RATE_W + ANGLE_W + 1;

  logic [ANGLE_W-1:0] angle_r, angle_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               cont_r, cont_nxt;

  logic [ANGLE_W-1:0]  target;
  logic signed [ANGLE_W:0] delta;
  logic [ANGLE_W-1:0]  mag;
  logic [TPROD_W-1:0]  tick_prod;
  logic [COUNT_W-1:0]  ticks;
  logic [ANGLE_W:0]    rot_sum;
  logic [ANGLE_W-1:0]  rot_angle;

  // set-angle arithmetic: clamp, distance, drive length
  always_comb begin
    if (item.goal_cdeg < 16'sd0) begin
      target = '0;
    end else if (item.goal_cdeg > $signed({1'b0, ANGLE_MAX})) begin
      target = ANGLE_MAX;
    end else begin
      target = item.goal_cdeg[ANGLE_W-1:0];
    end
    delta     = $signed({1'b0, target}) - $signed({1'b0, angle_r});
    mag       = (delta < 0) ? ANGLE_W'(-delta) : ANGLE_W'(delta);
    tick_prod = TPROD_W'(mag) * TPROD_W'(cfg.tick_rate)
              + (TPROD_W'(1) << (RATE_SHIFT - 1));
    ticks     = tick_prod[RATE_SHIFT +: COUNT_W];
  end

  // rotate: step the angle, clamped to the travel
  always_comb begin
    rot_sum = {1'b0, angle_r} + {1'b0, cfg.rotate_step};
    if (item.clockwise) begin
      rot_angle = (rot_sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : rot_sum[ANGLE_W-1:0];
    end else begin
      rot_angle = (cfg.rotate_step > angle_r) ? '0 : angle_r - cfg.rotate_step;
    end
  end

  // next state per operation
  always_comb begin
    angle_nxt = angle_r;
    level_nxt = level_r;
    count_nxt = count_r;
    cont_nxt  = cont_r;
    unique case (item.op)
      OP_TICK: begin
        if (count_r != '0) begin
          count_nxt = count_r - COUNT_W'(1);
          if (count_r == COUNT_W'(1)) begin
            level_nxt = cfg.level_stop;
          end
        end
      end
      OP_SET_ANGLE: begin
        angle_nxt = target;
        cont_nxt  = 1'b0;
        if (mag < DEADBAND || ticks == '0) begin
          level_nxt = cfg.level_stop;
          count_nxt = '0;
        end else begin
          level_nxt = (delta > 0) ? cfg.level_pos : cfg.level_neg;
          count_nxt = ticks;
        end
      end
      OP_ROTATE: begin
        angle_nxt = rot_angle;
        level_nxt = item.clockwise ? cfg.level_pos : cfg.level_neg;
        count_nxt = '0;
        cont_nxt  = 1'b1;
      end
      OP_STOP: begin
        level_nxt = cfg.level_stop;
        count_nxt = '0;
        cont_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= ANGLE_RESET;
      level_r <= LEVEL_RESET;
      count_r <= '0;
      cont_r  <= 1'b0;
    end else if (advance) begin
      angle_r <= angle_nxt;
      level_r <= level_nxt;
      count_r <= count_nxt;
      cont_r  <= cont_nxt;
    end
  end

  // result beat reflects the state after this item
  always_comb begin
    result.pulse_level  = level_nxt;
    result.angle        = angle_nxt;
    result.moving       = (count_nxt != '0) || cont_nxt;
    result.remaining_ms = count_nxt;
  end

endmodule

`default_nettype wire

FILE: design/open_loop_servo_positioner_top.sv
`default_nettype none

// Open-loop positioner for a continuous-rotation servo. Each input beat is a
// 1 ms tick, a set-angle, a rotate or a stop, and yields exactly one result
// beat with the PWM compare level, the simulated angle, the moving flag and
// the milliseconds left in a timed drive. One beat is taken every clock
// cycle while in_stall is low. Each beat passes the input register, then
// the result register, the pace being set by the update of the angle,
// level and countdown registers. Output stall holds the result register
// and, once the input register is also full, raises in_stall. Register
// writes reach the derived pulse levels and the drive-length rate through
// a further register, and are meant to be made while no beat is in flight.
// cfg_ready is always high. There is no memory and no clearing pass.

`include "open_loop_servo_positioner_top_assert.svh"

module open_loop_servo_positioner_top import osp_pkg::*; #(
  parameter int PERIOD_TICKS = 20000
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire osp_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output osp_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic     in_vld_r;
  osp_in_t  in_item_r;
  logic     out_vld_r;
  osp_out_t out_item_r;
  logic     advance;
  osp_cfg_t cfg;
  osp_out_t result;

  assign cfg_ready = 1'b1;

  osp_cfg #(
    .PERIOD_TICKS (PERIOD_TICKS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  osp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  // the input beat moves on when the result register is free or draining
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // checks
  `OSP_ASSERT_NOW(a_stall_only_when_blocked, in_stall, out_vld_r && out_stall,
                  "input stalled while the result register could drain")
  `OSP_ASSERT_NEXT(a_beat_reaches_result, advance, out_vld_r,
                   "input beat advanced but no result was registered")
  `OSP_ASSERT_NOW(a_countdown_means_moving,
                  out_valid && (out_data.remaining_ms != '0), out_data.moving,
                  "timed drive running but moving is low")
  `OSP_ASSERT_NOW(a_angle_in_travel, out_valid, out_data.angle <= ANGLE_MAX,
                  "angle beyond the travel range")

endmodule

`default_nettype wire
